// ===== sv/table_sine_cosine_assert.svh =====
// Assertion macros used by the RTL file.
`ifndef TABLE_SINE_COSINE_ASSERT_SVH
`define TABLE_SINE_COSINE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tsc_pkg.sv =====
package tsc_pkg;

  localparam int ANGLE_FRAC_BITS_DEF  = 16;
  localparam int RESULT_FRAC_BITS_DEF = 15;
  localparam int ANGLE_W              = 32;
  localparam int STAGES               = 13;

  localparam logic [29:0] RAD2DEG_Q24   = 30'd961263669;
  localparam logic [24:0] DEG2RAD_Q30   = 25'd18740330;
  localparam logic [23:0] DEG_RECIP_Q32 = 24'd11930465;
  localparam logic [3:0]  LAST_TEN      = 4'd9;

  function automatic logic [30:0] sin_tens(input logic [3:0] idx);
    logic [30:0] val;
    unique case (idx)
      4'd0:    val = 31'd0;
      4'd1:    val = 31'd186453311;
      4'd2:    val = 31'd367241333;
      4'd3:    val = 31'd536870912;
      4'd4:    val = 31'd690187940;
      4'd5:    val = 31'd822533958;
      4'd6:    val = 31'd929887697;
      4'd7:    val = 31'd1008987269;
      4'd8:    val = 31'd1057429273;
      4'd9:    val = 31'd1073741824;
      default: val = 31'd0;
    endcase
    return val;
  endfunction

  function automatic logic [30:0] cos_ones(input logic [3:0] idx);
    logic [30:0] val;
    unique case (idx)
      4'd0:    val = 31'd1073741824;
      4'd1:    val = 31'd1073578288;
      4'd2:    val = 31'd1073087729;
      4'd3:    val = 31'd1072270298;
      4'd4:    val = 31'd1071126243;
      4'd5:    val = 31'd1069655912;
      4'd6:    val = 31'd1067859754;
      4'd7:    val = 31'd1065738315;
      4'd8:    val = 31'd1063292242;
      4'd9:    val = 31'd1060522280;
      default: val = 31'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== sv/table_sine_cosine.sv =====
// Channel   Direction  Ports                              Contents
// in_       slave      in_tvalid in_tready in_tdata       angle in radians
//                      in_tuser                           sine or cosine select
// out_      master     out_tvalid out_tready out_tdata    signed sine or cosine
//
// One request is accepted per cycle unless a stall holds the first stage, and
// its result is driven from the last stage of the 13-stage pipeline.
// Reset clears only the stage valid bits.
// A stage holds while it and every stage after it are full and out_tready is
// low; empty stages keep filling, so no request is lost or repeated.
`include "table_sine_cosine_assert.svh"

module table_sine_cosine
  import tsc_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS  = ANGLE_FRAC_BITS_DEF,
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF,
  localparam int OUT_W       = RESULT_FRAC_BITS + 1,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [ANGLE_W-1:0]     in_tdata,   // [31:0] angle_radians
  input  logic [0:0]             in_tuser,   // [0] want_cosine
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [OUT_W-1:0] trig_value
);

  localparam int DEG_FRAC  = ANGLE_FRAC_BITS + 24;
  localparam int PROD_W    = ANGLE_W + 31;
  localparam int D_W       = PROD_W - DEG_FRAC;
  localparam int QP_W      = D_W + 25;
  localparam int Q_W       = QP_W - 32;
  localparam int DEG_SHIFT = DEG_FRAC - 32;
  localparam int RND_SHIFT = 60 - RESULT_FRAC_BITS;
  localparam int MAG_W     = RESULT_FRAC_BITS + 2;

  localparam logic signed [PROD_W-1:0] FULL_TURN    = PROD_W'(360) <<< DEG_FRAC;
  localparam logic signed [PROD_W-1:0] QUARTER_TURN = PROD_W'(90) <<< DEG_FRAC;
  localparam logic signed [10:0]       TURN_DEG     = 11'sd360;
  localparam logic [40:0]              DEG_360      = 41'd360 << 32;
  localparam logic [40:0]              DEG_180      = 41'd180 << 32;
  localparam logic [39:0]              FOLD_180     = 40'd180 << 32;
  localparam logic [39:0]              FOLD_90      = 40'd90 << 32;
  localparam logic [61:0]              RND_HALF     = 62'd1 << (RND_SHIFT - 1);
  localparam logic [MAG_W-1:0]         LIM          = MAG_W'(1) << RESULT_FRAC_BITS;
  localparam logic [STAGES-1:0]        ALL_FULL     = '1;

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] en;
  logic [11:5]       neg_r;

  logic signed [PROD_W-1:0] prod_r, prod2_r, prod3_r, rem_r;
  logic                     cos_r;
  logic signed [QP_W-1:0]   qprod_r;
  logic [40:0]              deg_r;
  logic [39:0]              half_r;
  logic [38:0]              fold_r;
  logic [3:0]               a_r, a8_r, a9_r;
  logic [3:0]               ib_r, ib8_r;
  logic [31:0]              bl_r;
  logic [61:0]              t1_r, t1_9_r, t1_10_r;
  logic [56:0]              bld_r;
  logic [27:0]              corr_r;
  logic [58:0]              t2_r;
  logic [MAG_W-1:0]         mag_r;
  logic [OUT_W-1:0]         res_r;

  logic signed [ANGLE_W-1:0] ang;
  logic signed [30:0]        k_s;
  logic signed [PROD_W-1:0]  prod_nxt, prod2_nxt, rem_nxt, fixed;
  logic signed [D_W-1:0]     d;
  logic signed [24:0]        recip_s;
  logic signed [QP_W-1:0]    qprod_nxt;
  logic signed [Q_W-1:0]     qest;
  logic signed [Q_W+10:0]    q360;
  logic [40:0]               deg_nxt;
  logic                      neg_nxt;
  logic [39:0]               half_nxt;
  logic [38:0]               fold_nxt;
  logic [6:0]                ip, a10;
  logic [14:0]               ip_x;
  logic [3:0]                a_nxt, ib_nxt, far_idx;
  logic [61:0]               t1_nxt;
  logic [56:0]               bld_nxt;
  logic [27:0]               ib_ext, d2r_ext, corr_nxt;
  logic [58:0]               t2_nxt;
  logic [61:0]               sum;
  logic [MAG_W-1:0]          mag_nxt, mag_c, mag_neg;
  logic [OUT_W-1:0]          res_nxt;

  always_comb begin
    for (int i = 0; i < STAGES; i++) begin
      en[i] = out_tready || ((v_r >> i) != (ALL_FULL >> i));
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[STAGES-1];
  assign out_tdata  = OUT_TDATA_W'(res_r);

  assign ang       = $signed(in_tdata);
  assign k_s       = $signed({1'b0, RAD2DEG_Q24});
  assign prod_nxt  = ang * k_s;
  assign prod2_nxt = prod_r + (cos_r ? QUARTER_TURN : '0);

  assign d         = $signed(prod2_r[PROD_W-1:DEG_FRAC]);
  assign recip_s   = $signed({1'b0, DEG_RECIP_Q32});
  assign qprod_nxt = d * recip_s;

  assign qest    = $signed(qprod_r[QP_W-1:32]);
  assign q360    = qest * TURN_DEG;
  assign rem_nxt = prod3_r - (PROD_W'(q360) <<< DEG_FRAC);

  always_comb begin
    if (rem_r[PROD_W-1]) begin
      fixed = rem_r + FULL_TURN;
    end else if (rem_r >= FULL_TURN) begin
      fixed = rem_r - FULL_TURN;
    end else begin
      fixed = rem_r;
    end
  end
  assign deg_nxt = fixed[DEG_SHIFT+40:DEG_SHIFT];

  assign neg_nxt  = deg_r >= DEG_180;
  assign half_nxt = 40'(neg_nxt ? deg_r - DEG_180 : deg_r);
  assign fold_nxt = 39'((half_r > FOLD_90) ? FOLD_180 - half_r : half_r);

  assign ip     = fold_r[38:32];
  assign ip_x   = 15'(ip) * 15'd205;
  assign a_nxt  = ip_x[14:11];
  assign a10    = {3'b000, a_nxt} * 7'd10;
  assign ib_nxt = 4'(ip - a10);

  assign t1_nxt  = sin_tens(a_r) * cos_ones(ib_r);
  assign bld_nxt = bl_r * DEG2RAD_Q30;

  assign ib_ext   = 28'(ib8_r);
  assign d2r_ext  = 28'(DEG2RAD_Q30);
  assign corr_nxt = ib_ext * d2r_ext + 28'(bld_r[56:32]);

  assign far_idx = LAST_TEN - a9_r;
  assign t2_nxt  = corr_r * sin_tens(far_idx);

  assign sum     = t1_10_r + 62'(t2_r) + RND_HALF;
  assign mag_nxt = MAG_W'(sum >> RND_SHIFT);

  assign mag_c   = (mag_r > LIM) ? LIM : mag_r;
  assign mag_neg = -mag_c;
  always_comb begin
    if (neg_r[11]) begin
      res_nxt = OUT_W'(mag_neg);
    end else if (mag_c > LIM - 1'b1) begin
      res_nxt = OUT_W'(LIM - 1'b1);
    end else begin
      res_nxt = OUT_W'(mag_c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= prod_nxt;
      cos_r  <= in_tuser[0];
    end
    if (en[1]) begin
      prod2_r <= prod2_nxt;
    end
    if (en[2]) begin
      qprod_r <= qprod_nxt;
      prod3_r <= prod2_r;
    end
    if (en[3]) begin
      rem_r <= rem_nxt;
    end
    if (en[4]) begin
      deg_r <= deg_nxt;
    end
    if (en[5]) begin
      half_r   <= half_nxt;
      neg_r[5] <= neg_nxt;
    end
    for (int i = 6; i <= 11; i++) begin
      if (en[i]) begin
        neg_r[i] <= neg_r[i-1];
      end
    end
    if (en[6]) begin
      fold_r <= fold_nxt;
    end
    if (en[7]) begin
      a_r  <= a_nxt;
      ib_r <= ib_nxt;
      bl_r <= fold_r[31:0];
    end
    if (en[8]) begin
      t1_r  <= t1_nxt;
      bld_r <= bld_nxt;
      a8_r  <= a_r;
      ib8_r <= ib_r;
    end
    if (en[9]) begin
      corr_r <= corr_nxt;
      t1_9_r <= t1_r;
      a9_r   <= a8_r;
    end
    if (en[10]) begin
      t2_r    <= t2_nxt;
      t1_10_r <= t1_9_r;
    end
    if (en[11]) begin
      mag_r <= mag_nxt;
    end
    if (en[12]) begin
      res_r <= res_nxt;
    end
  end

  `TSC_ASSERT_IMP(a_deg_reduced, v_r[4], deg_r < DEG_360, "Reduced angle is not below a full turn.")
  `TSC_ASSERT_IMP(a_fold_range, v_r[6], fold_r <= FOLD_90, "Folded angle is above a quarter turn.")
  `TSC_ASSERT_IMP(a_split_range, v_r[7], (a_r <= LAST_TEN) && (ib_r <= LAST_TEN), "Table index out of range.")
  `TSC_ASSERT_NXT(a_stall_hold, v_r[4] && !en[5], v_r[4] && $stable(deg_r), "Stalled stage lost its data.")

endmodule

// ===== sim/table_sine_cosine_tb.sv =====
module table_sine_cosine_tb;
  import tsc_pkg::*;

  localparam int RES_FRAC = 15;
  localparam int OUT_BITS = RES_FRAC + 1;
  localparam int DEG_FRAC = 40;
  localparam int ROUND_SHIFT = 60 - RES_FRAC;
  localparam longint RAD_TO_DEG_Q24 = 961263669;
  localparam bit [63:0] DEG_TO_RAD_Q30 = 64'd18740330;
  localparam bit [63:0] ONE_Q30 = 64'd1073741824;
  localparam bit [31:0] QUARTER_TURN = 32'd102944;
  localparam int PIPE_DEPTH = 13;
  localparam int CYCLE_LIMIT = 200000;

  localparam bit [63:0] SIN_TENS [10] = '{
    64'd0, 64'd186453311, 64'd367241333, 64'd536870912, 64'd690187940,
    64'd822533958, 64'd929887697, 64'd1008987269, 64'd1057429273, ONE_Q30
  };
  localparam bit [63:0] COS_ONES [10] = '{
    ONE_Q30, 64'd1073578288, 64'd1073087729, 64'd1072270298, 64'd1071126243,
    64'd1069655912, 64'd1067859754, 64'd1065738315, 64'd1063292242, 64'd1060522280
  };

  class trig_scoreboard;
    typedef struct {
      bit [31:0]         angle;
      bit                cosine;
      bit [OUT_BITS-1:0] value;
    } trig_entry_t;

    trig_entry_t awaited[$];
    int errors = 0;

    // Converts to degrees, folds into the first quadrant and interpolates
    // between the ten-degree table points.
    function bit [OUT_BITS-1:0] sine_cosine_of(bit [31:0] angle, bit cosine);
      longint ang, prod, rem, full;
      bit [63:0] deg, a, b, ib, t1, corr, t2, sum, mag;
      bit negative;
      full = longint'(360) <<< DEG_FRAC;
      ang = longint'($signed(angle));
      prod = ang * RAD_TO_DEG_Q24;
      if (cosine) begin
        prod += longint'(90) <<< DEG_FRAC;
      end
      rem = prod % full;
      if (rem < 0) begin
        rem += full;
      end
      deg = 64'(rem) >> (DEG_FRAC - 32);
      negative = 1'b0;
      if (deg >= (64'd180 << 32)) begin
        negative = 1'b1;
        deg -= 64'd180 << 32;
      end
      if (deg > (64'd90 << 32)) begin
        deg = (64'd180 << 32) - deg;
      end
      a = (deg >> 32) / 64'd10;
      if (a > 64'd9) begin
        a = 64'd9;
      end
      b = deg - ((a * 64'd10) << 32);
      ib = b >> 32;
      if (ib > 64'd9) begin
        ib = 64'd9;
      end
      t1 = SIN_TENS[a] * COS_ONES[ib];
      corr = (b * DEG_TO_RAD_Q30) >> 32;
      t2 = corr * SIN_TENS[64'd9 - a];
      sum = t1 + t2;
      mag = (sum + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      if (mag > (64'd1 << RES_FRAC)) begin
        mag = 64'd1 << RES_FRAC;
      end
      if (negative) begin
        return OUT_BITS'(64'd0 - mag);
      end
      if (mag > (64'd1 << RES_FRAC) - 64'd1) begin
        mag = (64'd1 << RES_FRAC) - 64'd1;
      end
      return OUT_BITS'(mag);
    endfunction

    function void note_request(bit [31:0] angle, bit cosine);
      trig_entry_t e;
      e.angle = angle;
      e.cosine = cosine;
      e.value = sine_cosine_of(angle, cosine);
      awaited.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) begin
        $display("mismatch: %s", msg);
      end
    endtask

    task check_result(logic [OUT_BITS-1:0] got);
      trig_entry_t e;
      if (awaited.size() == 0) begin
        report($sformatf("result %h with no request outstanding", got));
      end else begin
        e = awaited.pop_front();
        if (got !== e.value) begin
          report($sformatf("angle %h cosine %0d: trig_value %h, predicted %h",
                           e.angle, e.cosine, got, e.value));
        end
      end
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  trig_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;

  table_sine_cosine DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_request(in_tdata, in_tuser[0]);
      end
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata[OUT_BITS-1:0]);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAIL table_sine_cosine");
        $finish;
      end
    end
  end

  // The result side either sits out a long hold-off or stalls at random.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready = 1'b0;
        hold_cycles--;
      end else begin
        out_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task send_request(input bit [31:0] angle, input bit cosine);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = angle;
    in_tuser = cosine;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
  endtask

  task wait_all_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  function bit [31:0] pick_angle();
    int unsigned kind;
    bit [31:0] quarter;
    kind = $urandom_range(9);
    quarter = $urandom_range(40);
    if (kind < 5) begin
      return $urandom;
    end else if (kind < 8) begin
      return 32'($urandom_range(1048576)) - 32'd524288;
    end
    return quarter * QUARTER_TURN - 32'd20 * QUARTER_TURN + 32'($urandom_range(8)) - 32'd4;
  endfunction

  task run_phase(input int idle_pct, input int stall_pct, input int count,
                 input bit long_hold);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      if (long_hold && i == count / 3) begin
        hold_cycles = 80;
      end
      send_request(pick_angle(), 1'($urandom_range(1)));
    end
    wait_all_results();
  endtask

  bit [31:0] corner_angles [12] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, QUARTER_TURN, 32'd2 * QUARTER_TURN - 32'd1,
    32'd3 * QUARTER_TURN - 32'd1, 32'd4 * QUARTER_TURN - 32'd1,
    32'd0 - QUARTER_TURN, 32'h0001_0000, 32'hFFFF_0000
  };

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Table endpoints, both half-turn folds, saturation at 90 degrees and
    // the signed zero at 180 degrees, each for sine and cosine.
    foreach (corner_angles[i]) begin
      send_request(corner_angles[i], 1'b0);
      send_request(corner_angles[i], 1'b1);
    end
    wait_all_results();

    run_phase(0, 0, 100, 1'b1);
    run_phase(46, 0, 100, 1'b0);
    run_phase(0, 46, 100, 1'b1);
    run_phase(16, 16, 100, 1'b0);

    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS table_sine_cosine");
    end else begin
      $display("FAIL table_sine_cosine");
    end
    $finish;
  end

endmodule
